[rtl/hbed_pkg.sv]
// Shared types, codes and constants of the Haar box energy difference unit.
`default_nettype none

package hbed_pkg;

   // Window geometry: cells beyond these limits are ignored.
   localparam int NUM_BANDS   = 32;
   localparam int WINDOW_ROWS = 64;

   // Depth of the queue between classifier and accumulator.
   localparam int QUEUE_DEPTH = 4;

   // Field widths.
   localparam int ROW_W       = 6;
   localparam int BAND_W      = 5;
   localparam int ENERGY_W    = 24;
   localparam int DIFF_W      = 37;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   // Register indexes on the csr port.
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_TYPE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_FIRST  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_STOP   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_FIRST  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_STOP   = 3'd4;

   // Filter pattern codes; anything else yields zero.
   localparam logic [2:0] FT_BAND_HALVES = 3'd1;
   localparam logic [2:0] FT_TIME_HALVES = 3'd2;
   localparam logic [2:0] FT_QUADRANTS   = 3'd3;
   localparam logic [2:0] FT_BAND_STRIPE = 3'd4;
   localparam logic [2:0] FT_TIME_STRIPE = 3'd5;

   // Cell classes.
   localparam logic [1:0] CLS_NONE  = 2'd0;
   localparam logic [1:0] CLS_BLACK = 2'd1;
   localparam logic [1:0] CLS_WHITE = 2'd2;

   // Saturation bound of the running sum, one bit wider than the sum.
   localparam logic signed [DIFF_W:0] SUM_MAX = 38'sd34359738368;

   typedef struct packed {
      logic [2:0] filter_type;
      logic [5:0] band_first;
      logic [5:0] band_stop;
      logic [6:0] time_first;
      logic [6:0] time_stop;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          cls;
      logic [ENERGY_W-1:0] energy;
      logic                last;
   } cell_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

[rtl/hbed_front.sv]
// Front end: accepts cells and classifies them as black, white or outside.
`default_nettype none

module hbed_front (
   input  var hbed_pkg::cfg_type            cfg,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [hbed_pkg::ROW_W-1:0]       row_offset,
   input  wire  [hbed_pkg::BAND_W-1:0]      band_index,
   input  wire  [hbed_pkg::ENERGY_W-1:0]    cell_energy,
   input  wire                              last_cell,
   input  var hbed_pkg::qstat_type          q_stat,
   output logic                             push,
   output hbed_pkg::cell_type               push_cell
);

   function automatic logic in_rng(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
      return (v >= lo) && (v < hi);
   endfunction

   logic [7:0] r8, b8, bf8, bs8, tf8, ts8;
   logic [7:0] bmid, tmid;
   logic [7:0] bdiff, bq, blo, bhi;
   logic [7:0] tdiff, tq, tlo, thi;
   logic       in_b, in_t, bstripe_ok, tstripe_ok, win_ok;
   logic [1:0] cls;

   assign r8  = {2'b00, row_offset};
   assign b8  = {3'b000, band_index};
   assign bf8 = {2'b00, cfg.band_first};
   assign bs8 = {2'b00, cfg.band_stop};
   assign tf8 = {1'b0, cfg.time_first};
   assign ts8 = {1'b0, cfg.time_stop};

   // time midpoint follows the stop row only
   assign bmid = (bf8 + bs8) >> 1;
   assign tmid = ts8 >> 1;

   // stripe edges; meaningful only for a non-empty box
   assign bdiff = bs8 - bf8;
   assign bq    = {2'b00, bdiff[7:2]};
   assign blo   = bf8 + bq;
   assign bhi   = bf8 + bq + (bq << 1);
   assign tdiff = ts8 - tf8;
   assign tq    = {2'b00, tdiff[7:2]};
   assign tlo   = tf8 + tq;
   assign thi   = tf8 + tq + (tq << 1);

   assign bstripe_ok = bs8 > bf8;
   assign tstripe_ok = ts8 > tf8;
   assign in_b = in_rng(b8, bf8, bs8);
   assign in_t = in_rng(r8, tf8, ts8);

   assign win_ok = ({3'b000, row_offset} < 9'(hbed_pkg::WINDOW_ROWS)) &&
                   ({2'b00, band_index} < 7'(hbed_pkg::NUM_BANDS));

   always_comb begin
      cls = hbed_pkg::CLS_NONE;
      unique case (cfg.filter_type)
         hbed_pkg::FT_BAND_HALVES: begin
            if (in_t && in_rng(b8, bf8, bmid)) cls = hbed_pkg::CLS_WHITE;
            else if (in_t && in_rng(b8, bmid, bs8)) cls = hbed_pkg::CLS_BLACK;
         end
         hbed_pkg::FT_TIME_HALVES: begin
            if (in_b && in_rng(r8, tf8, tmid)) cls = hbed_pkg::CLS_WHITE;
            else if (in_b && in_rng(r8, tmid, ts8)) cls = hbed_pkg::CLS_BLACK;
         end
         hbed_pkg::FT_QUADRANTS: begin
            if (in_rng(r8, tf8, tmid) && in_rng(b8, bf8, bmid))
               cls = hbed_pkg::CLS_WHITE;
            else if (in_rng(r8, tf8, tmid) && in_rng(b8, bmid, bs8))
               cls = hbed_pkg::CLS_BLACK;
            else if (in_rng(r8, tmid, ts8) && in_rng(b8, bf8, bmid))
               cls = hbed_pkg::CLS_BLACK;
            else if (in_rng(r8, tmid, ts8) && in_rng(b8, bmid, bs8))
               cls = hbed_pkg::CLS_WHITE;
         end
         hbed_pkg::FT_BAND_STRIPE: begin
            if (in_t && bstripe_ok) begin
               if (in_rng(b8, bf8, blo)) cls = hbed_pkg::CLS_WHITE;
               else if (in_rng(b8, blo, bhi)) cls = hbed_pkg::CLS_BLACK;
               else if (in_rng(b8, bhi, bs8)) cls = hbed_pkg::CLS_WHITE;
            end
         end
         hbed_pkg::FT_TIME_STRIPE: begin
            if (in_b && tstripe_ok) begin
               if (in_rng(r8, tf8, tlo)) cls = hbed_pkg::CLS_WHITE;
               else if (in_rng(r8, tlo, thi)) cls = hbed_pkg::CLS_BLACK;
               else if (in_rng(r8, thi, ts8)) cls = hbed_pkg::CLS_WHITE;
            end
         end
         default: cls = hbed_pkg::CLS_NONE;
      endcase
      if (!win_ok) cls = hbed_pkg::CLS_NONE;
   end

   assign req_ready        = !q_stat.full;
   assign push             = req_valid && req_ready;
   assign push_cell.cls    = cls;
   assign push_cell.energy = cell_energy;
   assign push_cell.last   = last_cell;

endmodule

`default_nettype wire

[rtl/hbed_queue.sv]
// Small queue of classified cells between front end and accumulator.
`default_nettype none

module hbed_queue #(
   parameter int DEPTH = hbed_pkg::QUEUE_DEPTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  var hbed_pkg::cell_type push_cell,
   input  wire                 pop,
   output hbed_pkg::cell_type  head_cell,
   output hbed_pkg::qstat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hbed_pkg::cell_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cell;
   end

   assign head_cell    = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

[rtl/hbed_back.sv]
// Back end: saturating accumulate of classified cells and result register.
`default_nettype none

module hbed_back (
   input  wire                                clock,
   input  wire                                reset,
   input  var hbed_pkg::cell_type             head_cell,
   input  var hbed_pkg::qstat_type            q_stat,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [hbed_pkg::DIFF_W-1:0] rsp_diff
);

   localparam int DW = hbed_pkg::DIFF_W;

   logic signed [DW-1:0] sum_ff, sum_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic                 valid_ff, valid_in;
   logic signed [DW:0]   ext_sum, ext_e, raw, clamped;
   logic signed [DW-1:0] sat;
   logic                 slot_free;

   assign slot_free = !valid_ff || rsp_ready;
   // a last cell waits for the result slot; others always drain
   assign pop = !q_stat.empty && (!head_cell.last || slot_free);

   assign ext_sum = {sum_ff[DW-1], sum_ff};
   assign ext_e   = $signed({{(DW + 1 - hbed_pkg::ENERGY_W){1'b0}}, head_cell.energy});

   always_comb begin
      unique case (head_cell.cls)
         hbed_pkg::CLS_BLACK: raw = ext_sum + ext_e;
         hbed_pkg::CLS_WHITE: raw = ext_sum - ext_e;
         default:             raw = ext_sum;
      endcase
      if (raw > hbed_pkg::SUM_MAX) clamped = hbed_pkg::SUM_MAX;
      else if (raw < -hbed_pkg::SUM_MAX) clamped = -hbed_pkg::SUM_MAX;
      else clamped = raw;
   end

   assign sat = $signed(clamped[DW-1:0]);

   always_comb begin
      sum_in   = sum_ff;
      diff_in  = diff_ff;
      valid_in = valid_ff;
      if (pop) sum_in = head_cell.last ? '0 : sat;
      priority if (pop && head_cell.last) begin
         valid_in = 1'b1;
         diff_in  = sat;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_diff  = diff_ff;

endmodule

`default_nettype wire

[rtl/haar_box_energy_difference_unit.sv]
// Top level of the Haar box energy difference unit.
`default_nettype none

// Takes the cells of one spectrogram window, one transfer per clock while
// req_tready is high, and returns one signed black-minus-white energy total
// per window, sent when the cell flagged by req_tlast has been counted. Each
// cell is classified in the same cycle it is accepted (pattern and box come
// from the csr registers), then sits in a short queue until the accumulator
// adds or subtracts its energy with saturation at +/-2^35. Throughput is one
// cell per clock while req_tready is high; the accumulator's single
// add-and-clamp sets that figure. rsp_tvalid rises once the last cell has
// been popped from the queue. req_tready drops only when the queue
// (QUEUE_DEPTH entries) is full, which happens when a window's result is
// stalled on rsp_tready and further cells keep arriving. Write csr registers
// only while no window is in progress; csr_ready is always high.

module haar_box_energy_difference_unit #(
   parameter int QUEUE_DEPTH = hbed_pkg::QUEUE_DEPTH
) (
   input  wire                                clock,
   input  wire                                reset,
   // tdata: row_offset[5:0], band_index[10:6], cell_energy[34:11], zero fill
   input  wire  [hbed_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                                req_tlast,   // last_cell
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // tdata: energy_diff[36:0] (signed), zero fill
   output logic [hbed_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [hbed_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [hbed_pkg::CSR_DATA_W-1:0]    csr_data
);

   hbed_pkg::cfg_type   cfg_ff, cfg_in;
   hbed_pkg::cell_type  push_cell, head_cell;
   hbed_pkg::qstat_type q_stat;
   logic                q_push, q_pop;
   logic signed [hbed_pkg::DIFF_W-1:0] rsp_diff;

   // ---- configuration registers ----
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            hbed_pkg::REG_FILTER_TYPE: cfg_in.filter_type = csr_data[2:0];
            hbed_pkg::REG_BAND_FIRST:  cfg_in.band_first  = csr_data[5:0];
            hbed_pkg::REG_BAND_STOP:   cfg_in.band_stop   = csr_data[5:0];
            hbed_pkg::REG_TIME_FIRST:  cfg_in.time_first  = csr_data;
            hbed_pkg::REG_TIME_STOP:   cfg_in.time_stop   = csr_data;
            default:                   cfg_in = cfg_ff;   // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_type <= hbed_pkg::FT_BAND_HALVES;
         cfg_ff.band_first  <= 6'd0;
         cfg_ff.band_stop   <= 6'd32;
         cfg_ff.time_first  <= 7'd0;
         cfg_ff.time_stop   <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- front: accept and classify ----
   hbed_front u_front (
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .row_offset  (req_tdata[5:0]),
      .band_index  (req_tdata[10:6]),
      .cell_energy (req_tdata[34:11]),
      .last_cell   (req_tlast),
      .q_stat      (q_stat),
      .push        (q_push),
      .push_cell   (push_cell)
   );

   // ---- queue between front and back ----
   hbed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cell (push_cell),
      .pop       (q_pop),
      .head_cell (head_cell),
      .q_stat    (q_stat)
   );

   // ---- back: accumulate and hold the result ----
   hbed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cell (head_cell),
      .q_stat    (q_stat),
      .pop       (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_diff  (rsp_diff)
   );

   assign rsp_tdata = {{(hbed_pkg::RSP_DATA_W - hbed_pkg::DIFF_W){1'b0}}, rsp_diff};

   // ---- checks ----
   // a popped last cell always lands in the result register
   a_last_to_rsp: assert property (@(posedge clock) disable iff (reset)
      q_pop && head_cell.last |=> rsp_tvalid)
      else $error("last cell popped but no result presented");

   // the back end never drains an empty queue
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !q_pop)
      else $error("pop from empty queue");

   // a presented total lies within the saturation bounds
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed({rsp_diff[hbed_pkg::DIFF_W-1], rsp_diff}) <= hbed_pkg::SUM_MAX)
                  && ($signed({rsp_diff[hbed_pkg::DIFF_W-1], rsp_diff}) >= -hbed_pkg::SUM_MAX))
      else $error("result outside saturation range");

endmodule

`default_nettype wire
